>>> hdl/assert_macros.svh
// Assertion macros for the checker file of the color classifier.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> hdl/rrcc_pkg.sv
// Shared types, codes and the microcode ROM of the color classifier.
// No dependencies; imported by the sequencer, datapath, top level and checker.
`default_nettype none

package rrcc_pkg;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_SAMPLE_COUNT   = 2'd0;
   localparam logic [1:0] CSR_MIN_THRESHOLD  = 2'd1;
   localparam logic [1:0] CSR_MIN_DIFFERENCE = 2'd2;

   // Register reset values
   localparam logic [4:0] SAMPLE_COUNT_RST   = 5'd10;
   localparam logic [9:0] MIN_THRESHOLD_RST  = 10'd50;
   localparam logic [9:0] MIN_DIFFERENCE_RST = 10'd30;

   // Lighting phases
   localparam logic [1:0] PHASE_AMBIENT = 2'd0;
   localparam logic [1:0] PHASE_RED     = 2'd1;
   localparam logic [1:0] PHASE_GREEN   = 2'd2;
   localparam logic [1:0] PHASE_BLUE    = 2'd3;

   // A level counts as high when HIGH_NUM * level > HIGH_DEN * max (0.7 of max)
   localparam int HIGH_NUM = 10;
   localparam int HIGH_DEN = 7;

   typedef enum logic [3:0] {
      CLASS_UNDEF   = 4'd0,
      CLASS_RED     = 4'd1,
      CLASS_GREEN   = 4'd2,
      CLASS_BLUE    = 4'd3,
      CLASS_YELLOW  = 4'd4,
      CLASS_CYAN    = 4'd5,
      CLASS_MAGENTA = 4'd6,
      CLASS_WHITE   = 4'd7,
      CLASS_BLACK   = 4'd8
   } class_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NOP        = 4'd0,
      OP_ACCUM      = 4'd1,
      OP_DIV_INIT   = 4'd2,
      OP_DIV_STEP   = 4'd3,
      OP_STORE      = 4'd4,
      OP_COMPENSATE = 4'd5,
      OP_RANK       = 4'd6,
      OP_GRADE      = 4'd7,
      OP_EMIT       = 4'd8
   } op_type;

   // Jump conditions; a true condition loads the target
   typedef enum logic [2:0] {
      COND_NONE     = 3'd0,
      COND_NO_ITEM  = 3'd1,
      COND_RUN_OPEN = 3'd2,
      COND_DIV_BUSY = 3'd3,
      COND_NOT_BLUE = 3'd4,
      COND_OUT_BUSY = 3'd5,
      COND_ALWAYS   = 3'd6
   } cond_type;

   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] ENTRY_PC = 4'd0;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic            hold;    // suppress the op while the jump is taken
      logic [PC_W-1:0] target;
   } ucode_word_type;

   typedef struct packed {
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic run_open;
      logic div_busy;
      logic not_blue;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic [4:0] sample_count;
      logic [9:0] min_threshold;
      logic [9:0] min_difference;
   } cfg_type;

   // Microcode program
   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, hold: 1'b0, target: ENTRY_PC};
      unique case (pc)
         4'd0: w = '{op: OP_ACCUM,      cond: COND_NO_ITEM,  hold: 1'b1, target: 4'd0};
         4'd1: w = '{op: OP_NOP,        cond: COND_RUN_OPEN, hold: 1'b0, target: 4'd0};
         4'd2: w = '{op: OP_DIV_INIT,   cond: COND_NONE,     hold: 1'b0, target: 4'd0};
         4'd3: w = '{op: OP_DIV_STEP,   cond: COND_DIV_BUSY, hold: 1'b0, target: 4'd3};
         4'd4: w = '{op: OP_STORE,      cond: COND_NOT_BLUE, hold: 1'b0, target: 4'd0};
         4'd5: w = '{op: OP_COMPENSATE, cond: COND_NONE,     hold: 1'b0, target: 4'd0};
         4'd6: w = '{op: OP_RANK,       cond: COND_NONE,     hold: 1'b0, target: 4'd0};
         4'd7: w = '{op: OP_GRADE,      cond: COND_NONE,     hold: 1'b0, target: 4'd0};
         4'd8: w = '{op: OP_EMIT,       cond: COND_OUT_BUSY, hold: 1'b1, target: 4'd8};
         4'd9: w = '{op: OP_NOP,        cond: COND_ALWAYS,   hold: 1'b0, target: 4'd0};
         default: w = '{op: OP_NOP, cond: COND_ALWAYS, hold: 1'b0, target: ENTRY_PC};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> hdl/rrcc_seq.sv
// Microcode sequencer: step counter, ROM fetch and conditional jumps.
// Depends on rrcc_pkg.
`default_nettype none

module rrcc_seq
   import rrcc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_valid,
   input  wire status_type status,
   output ctrl_type        ctrl,
   output logic            at_entry
);

   logic [PC_W-1:0] pc_ff, pc_in;
   ucode_word_type  word;
   logic            jump;

   // Fetch the control word
   assign word     = ucode_rom(pc_ff);
   assign at_entry = (pc_ff == ENTRY_PC);

   // Evaluate the jump condition
   always_comb begin
      unique case (word.cond)
         COND_NONE:     jump = 1'b0;
         COND_NO_ITEM:  jump = ~item_valid;
         COND_RUN_OPEN: jump = status.run_open;
         COND_DIV_BUSY: jump = status.div_busy;
         COND_NOT_BLUE: jump = status.not_blue;
         COND_OUT_BUSY: jump = status.out_busy;
         COND_ALWAYS:   jump = 1'b1;
         default:       jump = 1'b1;
      endcase
   end

   // Drop the op on a held step while waiting
   always_comb begin
      ctrl.op = (word.hold && jump) ? OP_NOP : word.op;
      pc_in   = jump ? word.target : pc_ff + PC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ENTRY_PC;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/rrcc_datapath.sv
// Datapath: run accumulator, serial divider, phase averages, classifier
// steps and the result register. Depends on rrcc_pkg.
`default_nettype none

module rrcc_datapath
   import rrcc_pkg::*;
#(
   parameter int SAMPLE_BITS = 10,
   parameter int MAX_SAMPLES = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctrl_type               ctrl,
   input  wire cfg_type                cfg,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   input  wire logic [1:0]             req_phase,
   input  wire logic                   rsp_stall,
   output status_type                  status,
   output logic                        rsp_valid,
   output logic [3:0]                  rsp_color_class,
   output logic [SAMPLE_BITS-1:0]      rsp_red_level,
   output logic [SAMPLE_BITS-1:0]      rsp_green_level,
   output logic [SAMPLE_BITS-1:0]      rsp_blue_level
);

   localparam int SB  = SAMPLE_BITS;
   localparam int CW  = $clog2(MAX_SAMPLES + 1);
   localparam int SW  = SB + CW;
   localparam int DCW = $clog2(SW + 1);
   localparam int EW  = SB + 3;
   localparam int MW  = SB + 4;

   // Run state
   logic [SW-1:0]  sum_ff, sum_in;
   logic [CW-1:0]  taken_ff, taken_in;
   logic [1:0]     phase_ff, phase_in;
   logic [SB-1:0]  amb_ff, amb_in, red_ff, red_in, grn_ff, grn_in;
   // Divider
   logic [CW-1:0]  rem_ff, rem_in;
   logic [SW-1:0]  quo_ff, quo_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   // Classifier
   logic [SB-1:0]  lvl_r_ff, lvl_r_in, lvl_g_ff, lvl_g_in, lvl_b_ff, lvl_b_in;
   logic [SB-1:0]  max_ff, max_in;
   class_type      prim_ff, prim_in, class_ff, class_in;
   logic           black_ff, black_in, above_ff, above_in, over_ff, over_in;
   // Result register
   logic           rsp_valid_ff, rsp_valid_in;
   class_type      rsp_class_ff, rsp_class_in;
   logic [SB-1:0]  rsp_r_ff, rsp_r_in, rsp_g_ff, rsp_g_in, rsp_b_ff, rsp_b_in;

   logic [CW-1:0]  limit;
   logic           restart;
   logic [CW:0]    rem_shift;
   logic [CW:0]    rem_diff;
   logic [SB-1:0]  avg;
   logic [EW-1:0]  total, thr, thr2;
   logic [SB-1:0]  rank_max;
   class_type      rank_prim;
   logic [SB-1:0]  sp_rg, sp_rb, sp_gb, sp_max;
   logic           high_r, high_g, high_b;
   logic [MW-1:0]  max_scaled;

   function automatic logic [SB-1:0] spread(input logic [SB-1:0] a,
                                            input logic [SB-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Clamp the configured run length into 1..MAX_SAMPLES
   always_comb begin
      if (cfg.sample_count == '0) begin
         limit = CW'(1);
      end else if (int'(cfg.sample_count) > MAX_SAMPLES) begin
         limit = CW'(MAX_SAMPLES);
      end else begin
         limit = CW'(cfg.sample_count);
      end
   end

   assign restart   = (req_phase != phase_ff);
   assign rem_shift = {rem_ff, quo_ff[SW-1]};
   assign rem_diff  = rem_shift - {1'b0, taken_ff};
   assign avg       = quo_ff[SB-1:0];

   // Ranking terms
   assign total = EW'(lvl_r_ff) + EW'(lvl_g_ff) + EW'(lvl_b_ff);
   assign thr   = EW'(cfg.min_threshold);
   assign thr2  = thr << 1;

   always_comb begin
      rank_max  = lvl_r_ff;
      rank_prim = CLASS_RED;
      if (lvl_g_ff > rank_max) begin
         rank_max  = lvl_g_ff;
         rank_prim = CLASS_GREEN;
      end
      if (lvl_b_ff > rank_max) begin
         rank_max  = lvl_b_ff;
         rank_prim = CLASS_BLUE;
      end
   end

   // Grading terms
   always_comb begin
      sp_rg  = spread(lvl_r_ff, lvl_g_ff);
      sp_rb  = spread(lvl_r_ff, lvl_b_ff);
      sp_gb  = spread(lvl_g_ff, lvl_b_ff);
      sp_max = sp_rg;
      if (sp_rb > sp_max) sp_max = sp_rb;
      if (sp_gb > sp_max) sp_max = sp_gb;
      max_scaled = MW'(max_ff) * MW'(HIGH_DEN);
      high_r     = (MW'(lvl_r_ff) * MW'(HIGH_NUM)) > max_scaled;
      high_g     = (MW'(lvl_g_ff) * MW'(HIGH_NUM)) > max_scaled;
      high_b     = (MW'(lvl_b_ff) * MW'(HIGH_NUM)) > max_scaled;
   end

   // Op decode: hold everything the op does not touch
   always_comb begin
      sum_in       = sum_ff;
      taken_in     = taken_ff;
      phase_in     = phase_ff;
      amb_in       = amb_ff;
      red_in       = red_ff;
      grn_in       = grn_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      lvl_r_in     = lvl_r_ff;
      lvl_g_in     = lvl_g_ff;
      lvl_b_in     = lvl_b_ff;
      max_in       = max_ff;
      prim_in      = prim_ff;
      class_in     = class_ff;
      black_in     = black_ff;
      above_in     = above_ff;
      over_in      = over_ff;
      rsp_class_in = rsp_class_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_g_in     = rsp_g_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (ctrl.op)
         OP_NOP: begin
         end
         // Add the item to the run; a phase change restarts it
         OP_ACCUM: begin
            sum_in   = (restart ? '0 : sum_ff) + SW'(req_sample);
            taken_in = (restart ? '0 : taken_ff) + CW'(1);
            phase_in = req_phase;
         end
         OP_DIV_INIT: begin
            rem_in  = '0;
            quo_in  = sum_ff;
            dcnt_in = DCW'(SW);
         end
         // One restoring divide step per cycle
         OP_DIV_STEP: begin
            if (!rem_diff[CW]) begin
               rem_in = rem_diff[CW-1:0];
               quo_in = {quo_ff[SW-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[CW-1:0];
               quo_in = {quo_ff[SW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - DCW'(1);
         end
         OP_STORE: begin
            sum_in   = '0;
            taken_in = '0;
            case (phase_ff)
               PHASE_AMBIENT: amb_in = avg;
               PHASE_RED:     red_in = avg;
               PHASE_GREEN:   grn_in = avg;
               default: begin
               end
            endcase
         end
         // Subtract ambient, clamp at zero
         OP_COMPENSATE: begin
            lvl_r_in = (red_ff > amb_ff) ? red_ff - amb_ff : '0;
            lvl_g_in = (grn_ff > amb_ff) ? grn_ff - amb_ff : '0;
            lvl_b_in = (avg > amb_ff) ? avg - amb_ff : '0;
         end
         OP_RANK: begin
            black_in = total < thr;
            above_in = (EW'(lvl_r_ff) > thr2) && (EW'(lvl_g_ff) > thr2) &&
                       (EW'(lvl_b_ff) > thr2);
            max_in   = rank_max;
            prim_in  = rank_prim;
            over_in  = EW'(rank_max) > thr;
         end
         OP_GRADE: begin
            if (black_ff) begin
               class_in = CLASS_BLACK;
            end else if (above_ff && (EW'(sp_max) < EW'(cfg.min_difference))) begin
               class_in = CLASS_WHITE;
            end else if (high_r && high_g) begin
               class_in = CLASS_YELLOW;
            end else if (high_g && high_b) begin
               class_in = CLASS_CYAN;
            end else if (high_r && high_b) begin
               class_in = CLASS_MAGENTA;
            end else if (over_ff) begin
               class_in = prim_ff;
            end else begin
               class_in = CLASS_UNDEF;
            end
         end
         OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_class_in = class_ff;
            rsp_r_in     = lvl_r_ff;
            rsp_g_in     = lvl_g_ff;
            rsp_b_in     = lvl_b_ff;
         end
         default: begin
         end
      endcase
   end

   // Control and model state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         taken_ff     <= '0;
         phase_ff     <= PHASE_AMBIENT;
         amb_ff       <= '0;
         red_ff       <= '0;
         grn_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         taken_ff     <= taken_in;
         phase_ff     <= phase_in;
         amb_ff       <= amb_in;
         red_ff       <= red_in;
         grn_ff       <= grn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dcnt_ff      <= dcnt_in;
      lvl_r_ff     <= lvl_r_in;
      lvl_g_ff     <= lvl_g_in;
      lvl_b_ff     <= lvl_b_in;
      max_ff       <= max_in;
      prim_ff      <= prim_in;
      class_ff     <= class_in;
      black_ff     <= black_in;
      above_ff     <= above_in;
      over_ff      <= over_in;
      rsp_class_ff <= rsp_class_in;
      rsp_r_ff     <= rsp_r_in;
      rsp_g_ff     <= rsp_g_in;
      rsp_b_ff     <= rsp_b_in;
   end

   assign status.run_open = taken_ff < limit;
   assign status.div_busy = dcnt_ff != DCW'(1);
   assign status.not_blue = phase_ff != PHASE_BLUE;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_class = rsp_class_ff;
   assign rsp_red_level   = rsp_r_ff;
   assign rsp_green_level = rsp_g_ff;
   assign rsp_blue_level  = rsp_b_ff;

endmodule

`default_nettype wire

>>> hdl/rgb_reflectance_color_classifier.sv
// Color classifier from phase-tagged light samples: top level.
// Depends on rrcc_pkg, rrcc_seq and rrcc_datapath.
//
// Usage:
//   req_ channel carries one light sample and its lighting phase (0 ambient,
//   1 red, 2 green, 3 blue). A run of sample_count samples of one phase is
//   averaged; a phase change restarts the run.
//   rsp_ channel carries one item each time a blue run completes: the class
//   code and the three ambient-compensated levels.
//   csr_ port writes sample_count, min_threshold, min_difference at index 0..2.
// Sequence, with SW = SAMPLE_BITS + clog2(MAX_SAMPLES+1) (15 at defaults):
//   An item that does not complete a run passes the accumulate step and the
//   run check. An item completing a run runs a bit-serial divider, one
//   quotient bit per cycle for SW bits, then stores the average of ambient,
//   red or green. A completed blue run goes on to compensate, rank, grade
//   and emit; rsp_valid rises from the emit step, then req_ is ready again.
// The rsp_ output register holds a result while rsp_stall is high; input
//   items keep being taken until the next result is ready, then req_ stalls.
// Reset clears the runs, the stored averages and the registers to their
//   default values (10, 50, 30); no result is pending after reset.
`default_nettype none

module rgb_reflectance_color_classifier
   import rrcc_pkg::*;
#(
   parameter int SAMPLE_BITS = 10,
   parameter int MAX_SAMPLES = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Configuration port
   input  wire logic                   csr_write,
   input  wire logic [1:0]             csr_addr,
   input  wire logic [9:0]             csr_wdata,
   // Sample items
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   input  wire logic [1:0]             req_phase,
   // Result items
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [3:0]                  rsp_color_class,
   output logic [SAMPLE_BITS-1:0]      rsp_red_level,
   output logic [SAMPLE_BITS-1:0]      rsp_green_level,
   output logic [SAMPLE_BITS-1:0]      rsp_blue_level
);

   cfg_type    cfg_ff;
   ctrl_type   ctrl;
   status_type status;
   logic       at_entry;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_count   <= SAMPLE_COUNT_RST;
         cfg_ff.min_threshold  <= MIN_THRESHOLD_RST;
         cfg_ff.min_difference <= MIN_DIFFERENCE_RST;
      end else if (csr_write) begin
         case (csr_addr)
            CSR_SAMPLE_COUNT:   cfg_ff.sample_count   <= csr_wdata[4:0];
            CSR_MIN_THRESHOLD:  cfg_ff.min_threshold  <= csr_wdata;
            CSR_MIN_DIFFERENCE: cfg_ff.min_difference <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Take an item only at the program entry step
   assign req_stall = ~at_entry;

   rrcc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_valid),
      .status     (status),
      .ctrl       (ctrl),
      .at_entry   (at_entry)
   );

   rrcc_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .cfg             (cfg_ff),
      .req_sample      (req_sample),
      .req_phase       (req_phase),
      .rsp_stall       (rsp_stall),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_color_class (rsp_color_class),
      .rsp_red_level   (rsp_red_level),
      .rsp_green_level (rsp_green_level),
      .rsp_blue_level  (rsp_blue_level)
   );

endmodule

`default_nettype wire

>>> hdl/rrcc_checker.sv
// Port-level checker for the color classifier, bound to the top level.
// Depends on rrcc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rrcc_checker
   import rrcc_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [3:0]             rsp_color_class,
   input wire logic [SAMPLE_BITS-1:0] rsp_red_level,
   input wire logic [SAMPLE_BITS-1:0] rsp_green_level,
   input wire logic [SAMPLE_BITS-1:0] rsp_blue_level
);

   // Hold a stalled result
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_color_class) && $stable(rsp_red_level) && $stable(rsp_green_level) && $stable(rsp_blue_level), "stalled result changed")

   // Class code stays within the defined codes
   `ASSERT_IMPLIES(a_class_range, clock, reset, rsp_valid, rsp_color_class <= CLASS_BLACK, "class code out of range")

   // White needs all three levels above twice the threshold, so none is zero
   `ASSERT_IMPLIES(a_white_levels, clock, reset, rsp_valid && (rsp_color_class == CLASS_WHITE), (rsp_red_level != '0) && (rsp_green_level != '0) && (rsp_blue_level != '0), "white with a zero level")

   // An accepted item is checked for run end before the next one, never emitted at once
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall && !$rose(rsp_valid), "item taken or result raised right after acceptance")

endmodule

bind rgb_reflectance_color_classifier rrcc_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_rrcc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_color_class (rsp_color_class),
   .rsp_red_level   (rsp_red_level),
   .rsp_green_level (rsp_green_level),
   .rsp_blue_level  (rsp_blue_level)
);

`default_nettype wire

>>> bench/rgb_reflectance_color_classifier_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the phase-tagged light sample color classifier.
// Needs rrcc_pkg and rgb_reflectance_color_classifier; predicts every result in place.

module rgb_reflectance_color_classifier_test;
   import rrcc_pkg::*;

   localparam int SAMPLE_W       = 10;
   localparam int MAX_RUN        = 16;
   localparam int IDLE_MAX       = 12;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TARGET_ITEMS   = 400;
   localparam int PHASE_ITEMS    = 50;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic [1:0]          phase;
      bit                  drain_first;   // wait for all pending results first
   } light_item_type;

   typedef struct {
      class_type           cls;
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
   } color_result_type;

   // Block ports
   logic                clock;
   logic                reset     = 1'b1;
   logic                csr_write = 1'b0;
   logic [1:0]          csr_addr  = '0;
   logic [9:0]          csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic [1:0]          req_phase  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [3:0]          rsp_color_class;
   logic [SAMPLE_W-1:0] rsp_red_level;
   logic [SAMPLE_W-1:0] rsp_green_level;
   logic [SAMPLE_W-1:0] rsp_blue_level;

   // Stimulus and scoreboard
   light_item_type   sample_queue[$];
   color_result_type expected_colors[$];
   bit            drain_next = 1'b0;
   bit            idle_on    = 1'b1;
   bit            req_taken  = 1'b0;
   bit            rsp_taken  = 1'b0;
   int            send_gap   = 0;
   int            hold_left  = 0;
   int            gen_limit  = SAMPLE_COUNT_RST;
   int            items_pushed    = 0;
   int            results_checked = 0;
   int            settings_used   = 0;
   int            mismatch_count  = 0;
   int            quiet_cycles    = 0;
   bit [8:0]      classes_seen    = '0;

   // Predictor copy of the registers and the run state
   logic [4:0]          run_target;
   logic [9:0]          level_floor;
   logic [9:0]          white_spread;
   logic [13:0]         acc_sum;
   logic [4:0]          acc_len;
   logic [1:0]          acc_phase;
   logic [SAMPLE_W-1:0] avg_ambient;
   logic [SAMPLE_W-1:0] avg_red;
   logic [SAMPLE_W-1:0] avg_green;

   rgb_reflectance_color_classifier i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_phase       (req_phase),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_color_class (rsp_color_class),
      .rsp_red_level   (rsp_red_level),
      .rsp_green_level (rsp_green_level),
      .rsp_blue_level  (rsp_blue_level)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] MISMATCH %s", $time, msg);
   endtask

   // Level above ambient, clamped at zero
   function automatic int net_of_ambient(input logic [SAMPLE_W-1:0] level);
      return (level > avg_ambient) ? int'(level - avg_ambient) : 0;
   endfunction

   function automatic int spread_of(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic class_type grade_color(input int r, input int g, input int b);
      int        t;
      int        top;
      int        widest;
      class_type lead;
      bit        hr;
      bit        hg;
      bit        hb;
      t = int'(level_floor);
      if (r + g + b < t) return CLASS_BLACK;
      if (r > 2 * t && g > 2 * t && b > 2 * t) begin
         widest = spread_of(r, g);
         if (spread_of(r, b) > widest) widest = spread_of(r, b);
         if (spread_of(g, b) > widest) widest = spread_of(g, b);
         if (widest < int'(white_spread)) return CLASS_WHITE;
      end
      top  = r;
      lead = CLASS_RED;
      if (g > top) begin
         top  = g;
         lead = CLASS_GREEN;
      end
      if (b > top) begin
         top  = b;
         lead = CLASS_BLUE;
      end
      // high means above 0.7 of the largest level
      hr = HIGH_NUM * r > HIGH_DEN * top;
      hg = HIGH_NUM * g > HIGH_DEN * top;
      hb = HIGH_NUM * b > HIGH_DEN * top;
      if (hr && hg) return CLASS_YELLOW;
      if (hg && hb) return CLASS_CYAN;
      if (hr && hb) return CLASS_MAGENTA;
      if (top > t) return lead;
      return CLASS_UNDEF;
   endfunction

   // Fold one accepted sample into the run; queue a result when a blue run closes
   task automatic absorb_sample(input logic [SAMPLE_W-1:0] s, input logic [1:0] ph);
      int                  lim;
      int                  r;
      int                  g;
      int                  b;
      logic [SAMPLE_W-1:0] avg;
      color_result_type    res;
      if (ph != acc_phase) begin
         acc_sum   = '0;
         acc_len   = '0;
         acc_phase = ph;
      end
      acc_sum = acc_sum + s;
      acc_len = acc_len + 1'b1;
      lim = (run_target == 0) ? 1 : (run_target > MAX_RUN) ? MAX_RUN : int'(run_target);
      if (acc_len >= lim) begin
         avg     = SAMPLE_W'(acc_sum / acc_len);
         acc_sum = '0;
         acc_len = '0;
         case (ph)
            PHASE_AMBIENT: avg_ambient = avg;
            PHASE_RED:     avg_red = avg;
            PHASE_GREEN:   avg_green = avg;
            default: begin
               r = net_of_ambient(avg_red);
               g = net_of_ambient(avg_green);
               b = net_of_ambient(avg);
               res.cls   = grade_color(r, g, b);
               res.red   = SAMPLE_W'(r);
               res.green = SAMPLE_W'(g);
               res.blue  = SAMPLE_W'(b);
               classes_seen[res.cls] = 1'b1;
               expected_colors.push_back(res);
            end
         endcase
      end
   endtask

   // Track register writes and accepted items, check results, guard against hangs
   always @(posedge clock) begin : scoreboard
      color_result_type want;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (reset) begin
         run_target   = SAMPLE_COUNT_RST;
         level_floor  = MIN_THRESHOLD_RST;
         white_spread = MIN_DIFFERENCE_RST;
         acc_sum      = '0;
         acc_len      = '0;
         acc_phase    = PHASE_AMBIENT;
         avg_ambient  = '0;
         avg_red      = '0;
         avg_green    = '0;
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (csr_write) begin
            case (csr_addr)
               CSR_SAMPLE_COUNT:   run_target = csr_wdata[4:0];
               CSR_MIN_THRESHOLD:  level_floor = csr_wdata;
               CSR_MIN_DIFFERENCE: white_spread = csr_wdata;
               default: begin end
            endcase
         end
         if (req_valid && !req_stall) begin
            req_taken    = 1'b1;
            quiet_cycles = 0;
            absorb_sample(req_sample, req_phase);
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            rsp_taken    = 1'b1;
            quiet_cycles = 0;
            results_checked++;
            if (expected_colors.size() == 0) begin
               report_mismatch($sformatf("result with none pending: class %0d levels %0d %0d %0d",
                  rsp_color_class, rsp_red_level, rsp_green_level, rsp_blue_level));
            end else begin
               want = expected_colors.pop_front();
               if (rsp_color_class !== want.cls)
                  report_mismatch($sformatf("color_class got %0d expected %0d",
                     rsp_color_class, want.cls));
               if (rsp_red_level !== want.red)
                  report_mismatch($sformatf("red_level got %0d expected %0d",
                     rsp_red_level, want.red));
               if (rsp_green_level !== want.green)
                  report_mismatch($sformatf("green_level got %0d expected %0d",
                     rsp_green_level, want.green));
               if (rsp_blue_level !== want.blue)
                  report_mismatch($sformatf("blue_level got %0d expected %0d",
                     rsp_blue_level, want.blue));
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no item moved for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Sample driver: hold the item until taken, then idle for a drawn gap
   always @(negedge clock) begin : sample_driver
      light_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the stalled item
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (sample_queue.size() != 0 &&
                   !(sample_queue[0].drain_first && expected_colors.size() != 0)) begin
         next_item   = sample_queue.pop_front();
         req_sample <= next_item.sample;
         req_phase  <= next_item.phase;
         req_valid  <= 1'b1;
         send_gap    = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result receiver: stall each result for a drawn number of valid cycles
   always @(negedge clock) begin : result_receiver
      if (reset) begin
         hold_left  = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_taken) hold_left = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
         else if (rsp_valid === 1'b1 && hold_left > 0) hold_left--;
         rsp_stall <= (hold_left != 0);
      end
   end

   task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic [1:0] ph);
      light_item_type it;
      it.sample      = s;
      it.phase       = ph;
      it.drain_first = drain_next;
      drain_next     = 1'b0;
      sample_queue.push_back(it);
      items_pushed++;
   endtask

   // Queue n samples of one phase around a level, with a little jitter
   task automatic push_run(input logic [1:0] ph, input int level, input int n);
      int s;
      for (int k = 0; k < n; k++) begin
         s = level + int'($urandom_range(0, 6)) - 3;
         if (s < 0) s = 0;
         if (s > 1023) s = 1023;
         push_sample(SAMPLE_W'(s), ph);
      end
   endtask

   // One full measurement: ambient, red, green and blue runs aimed at a mix of classes
   task automatic push_sequence();
      int amb;
      int top;
      int pick;
      int lvl[3];
      amb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 150);
      top = $urandom_range(0, 1023 - amb);
      foreach (lvl[c]) begin
         pick = $urandom_range(0, 3);
         case (pick)
            0:       lvl[c] = top;
            1:       lvl[c] = top - $urandom_range(0, top / 8);
            2:       lvl[c] = top * $urandom_range(60, 80) / 100;
            default: lvl[c] = $urandom_range(0, top);
         endcase
      end
      // now and then reuse the stored ambient average
      if ($urandom_range(0, 9) != 0) push_run(PHASE_AMBIENT, amb, gen_limit);
      push_run(PHASE_RED, amb + lvl[0], gen_limit);
      push_run(PHASE_GREEN, amb + lvl[1], gen_limit);
      push_run(PHASE_BLUE, amb + lvl[2], gen_limit);
   endtask

   // Write all three registers on consecutive cycles; only called while idle
   task automatic configure(input logic [4:0] cnt, input logic [9:0] thr, input logic [9:0] dif);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_addr  <= CSR_SAMPLE_COUNT;
      csr_wdata <= {5'($urandom_range(0, 31)), cnt};
      @(negedge clock);
      csr_addr  <= CSR_MIN_THRESHOLD;
      csr_wdata <= thr;
      @(negedge clock);
      csr_addr  <= CSR_MIN_DIFFERENCE;
      csr_wdata <= dif;
      @(negedge clock);
      csr_write <= 1'b0;
      gen_limit = (cnt == 0) ? 1 : (cnt > MAX_RUN) ? MAX_RUN : int'(cnt);
      settings_used++;
   endtask

   // Drain: all items sent, all results back, then let the divider finish;
   // look at the queue on rising edges, where the driver never touches it
   task automatic settle();
      @(posedge clock);
      while (sample_queue.size() != 0 || req_valid || expected_colors.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [4:0] cnt;
      logic [9:0] thr;
      logic [9:0] dif;
      int         setting;
      int         pick;
      int         phase_start;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Reset register values: a partial ambient run is dropped, then a blue
      // run closes over the zero averages left by reset
      push_sample(10'd1023, PHASE_AMBIENT);
      repeat (SAMPLE_COUNT_RST) push_sample(10'd1023, PHASE_BLUE);
      // open a green run, then shorten the run length under it
      push_sample(10'd1023, PHASE_GREEN);
      push_sample(10'd0, PHASE_GREEN);
      settle();
      configure(5'd1, MIN_THRESHOLD_RST, MIN_DIFFERENCE_RST);
      push_sample(10'd1022, PHASE_GREEN);
      // single-sample runs walk through the classes
      push_sample(10'd0, PHASE_AMBIENT);
      push_sample(10'd1023, PHASE_RED);
      push_sample(10'd1023, PHASE_BLUE);
      push_sample(10'd1023, PHASE_GREEN);
      push_sample(10'd1023, PHASE_BLUE);
      push_sample(10'd0, PHASE_RED);
      push_sample(10'd1023, PHASE_BLUE);
      push_sample(10'd1023, PHASE_RED);
      push_sample(10'd0, PHASE_BLUE);
      push_sample(10'd40, PHASE_RED);
      push_sample(10'd20, PHASE_GREEN);
      push_sample(10'd0, PHASE_BLUE);
      push_sample(10'd400, PHASE_GREEN);
      push_sample(10'd100, PHASE_BLUE);
      push_sample(10'd1023, PHASE_AMBIENT);
      push_sample(10'd0, PHASE_BLUE);
      settle();

      // Random part: mostly well-formed measurements, some broken runs and noise
      setting = 0;
      while (items_pushed < TARGET_ITEMS) begin
         case (setting)
            0: begin
               cnt = 5'd16;
               thr = 10'd1023;
               dif = 10'd1023;
            end
            1: begin
               cnt = 5'd0;
               thr = 10'd0;
               dif = 10'd0;
            end
            2: begin
               cnt = 5'd31;
               thr = 10'($urandom_range(0, 60));
               dif = 10'($urandom_range(0, 1023));
            end
            default: begin
               pick = $urandom_range(0, 9);
               if (pick < 6) cnt = 5'($urandom_range(1, 4));
               else if (pick < 8) cnt = 5'($urandom_range(5, 16));
               else if (pick < 9) cnt = 5'd0;
               else cnt = 5'($urandom_range(17, 31));
               thr = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                                 : 10'($urandom_range(0, 120));
               dif = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                 : 10'($urandom_range(0, 120));
            end
         endcase
         configure(cnt, thr, dif);
         idle_on     = (setting == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         phase_start = items_pushed;
         while (items_pushed - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               if (setting == 3 || $urandom_range(0, 7) == 0) drain_next = 1'b1;
               push_sequence();
            end else if (pick < 9) begin
               push_run(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                        $urandom_range(1, gen_limit + 1));
            end else begin
               push_sample(10'($urandom_range(0, 1023)), 2'($urandom_range(0, 3)));
            end
         end
         settle();
         setting++;
      end

      settle();
      $display("Sent %0d light samples under %0d register settings; checked %0d color results.",
               items_pushed, settings_used, results_checked);
      $display("Predicted results spanned %0d of the 9 color classes.", $countones(classes_seen));
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/rrcc_pkg.sv
hdl/rrcc_seq.sv
hdl/rrcc_datapath.sv
hdl/rgb_reflectance_color_classifier.sv
hdl/rrcc_checker.sv
bench/rgb_reflectance_color_classifier_test.sv
